### design/crl_pkg.sv
// Shared types and constants for the circular ring list engine.
package crl_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int STEP_W    = 8;
	localparam int CNT_W     = 5;

	localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_SLOTS);
	localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_ZERO = '0;
	localparam logic [SLOT_W-1:0] HOP_LAST = SLOT_W'(MAX_SLOTS - 1);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_PASS   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [SLOT_W-1:0]  slot;
		logic [STEP_W-1:0]  steps;
	} req_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  result_slot;
		status_t            status;
		logic [CNT_W-1:0]   member_count;
	} rsp_item_t;

endpackage

### design/circular_ring_list_engine.sv
// Top level of the circular ring list engine: sequencer, link RAM, result register.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+----------------------
//   req     | in        | req_item_t  | req_valid / req_ready
//   rsp     | out       | rsp_item_t  | rsp_valid / rsp_ready
//
// One item at a time. A remove walks the links from the tail to the predecessor of the
// slot (at most 15 hops) and reports the slot not found after at most 16 link reads;
// a pass follows one link per step.
// Each hop is one read of the single-port link RAM.
// Reset empties the ring; the link RAM is not cleared and needs no sweep.
// A result waits in the output register while the next item is taken.
module circular_ring_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  crl_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output crl_pkg::rsp_item_t rsp
);
	import crl_pkg::*;

	logic              res_valid;
	logic              res_ready;
	rsp_item_t         res;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_addr;
	logic [SLOT_W-1:0] ram_wdata;
	logic [SLOT_W-1:0] ram_rdata;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	crl_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	crl_ram #(
		.DEPTH (MAX_SLOTS),
		.WIDTH (SLOT_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// take a new result when the output register is free or draining
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	// hold the result payload
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/crl_ram.sv
// Single-port synchronous RAM with registered read data.
module crl_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write when enabled, otherwise read the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/crl_walker.sv
// Operation sequencer: holds head, tail and count, walks the next-pointer RAM.
module crl_walker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  crl_pkg::req_item_t        req,
	output logic                      res_valid,
	input  logic                      res_ready,
	output crl_pkg::rsp_item_t        res,
	output logic                      ram_we,
	output logic [crl_pkg::SLOT_W-1:0] ram_addr,
	output logic [crl_pkg::SLOT_W-1:0] ram_wdata,
	input  logic [crl_pkg::SLOT_W-1:0] ram_rdata
);
	import crl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS2,
		S_RM_WALK,
		S_RM_FOLLOW,
		S_PASS,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   prev_q;
	logic [SLOT_W-1:0]   hops_q;
	logic [STEP_W-1:0]   left_q;
	rsp_item_t           res_q;
	logic                req_fire;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// drive the RAM port from the current step
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = tail_q;
		ram_wdata = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.mode == MODE_INSERT) begin
					ram_addr  = req.slot;
					ram_wdata = (count_q == CNT_ZERO) ? req.slot : head_q;
					ram_we    = req_valid && (count_q != CNT_FULL);
				end else if (req.mode == MODE_PASS) begin
					ram_addr = req.slot;
				end
			end
			S_INS2: begin
				ram_we    = 1'b1;
				ram_addr  = tail_q;
				ram_wdata = slot_q;
			end
			S_RM_WALK: begin
				ram_addr = (ram_rdata == slot_q) ? slot_q : ram_rdata;
			end
			S_RM_FOLLOW: begin
				ram_we    = (count_q != CNT_ONE);
				ram_addr  = prev_q;
				ram_wdata = ram_rdata;
			end
			S_PASS: begin
				ram_addr = ram_rdata;
			end
			S_DONE: begin
				ram_addr = tail_q;
			end
			default: begin
				ram_addr = tail_q;
			end
		endcase
	end

	// sequence each item and hold its result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						slot_q <= req.slot;
						unique case (req.mode)
							MODE_INSERT: begin
								if (count_q == CNT_FULL) begin
									res_q   <= '{'0, ST_FULL, count_q};
									state_q <= S_DONE;
								end else if (count_q == CNT_ZERO) begin
									head_q  <= req.slot;
									tail_q  <= req.slot;
									count_q <= CNT_ONE;
									res_q   <= '{req.slot, ST_OK, CNT_ONE};
									state_q <= S_DONE;
								end else begin
									state_q <= S_INS2;
								end
							end
							MODE_REMOVE: begin
								if (count_q == CNT_ZERO) begin
									res_q   <= '{'0, ST_EMPTY, count_q};
									state_q <= S_DONE;
								end else begin
									prev_q  <= tail_q;
									hops_q  <= '0;
									state_q <= S_RM_WALK;
								end
							end
							MODE_PASS: begin
								if (count_q == CNT_ZERO) begin
									res_q   <= '{'0, ST_EMPTY, count_q};
									state_q <= S_DONE;
								end else if (req.steps == '0) begin
									res_q   <= '{req.slot, ST_OK, count_q};
									state_q <= S_DONE;
								end else begin
									left_q  <= req.steps;
									state_q <= S_PASS;
								end
							end
							MODE_CLEAR: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
								res_q   <= '{'0, ST_OK, CNT_ZERO};
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// link the old tail to the new head
				S_INS2: begin
					head_q  <= slot_q;
					count_q <= count_q + CNT_ONE;
					res_q   <= '{slot_q, ST_OK, count_q + CNT_ONE};
					state_q <= S_DONE;
				end
				// advance one hop looking for the predecessor
				S_RM_WALK: begin
					if (ram_rdata == slot_q) begin
						state_q <= S_RM_FOLLOW;
					end else if (ram_rdata == tail_q || hops_q == HOP_LAST) begin
						res_q   <= '{head_q, ST_NOT_FOUND, count_q};
						state_q <= S_DONE;
					end else begin
						prev_q <= ram_rdata;
						hops_q <= hops_q + SLOT_W'(1);
					end
				end
				// unlink the slot and repair head and tail
				S_RM_FOLLOW: begin
					if (count_q == CNT_ONE) begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= '0;
						res_q   <= '{'0, ST_EMPTY, CNT_ZERO};
					end else begin
						if (slot_q == head_q) begin
							head_q <= ram_rdata;
						end
						if (slot_q == tail_q) begin
							tail_q <= prev_q;
						end
						count_q <= count_q - CNT_ONE;
						res_q   <= '{ram_rdata, ST_OK, count_q - CNT_ONE};
					end
					state_q <= S_DONE;
				end
				// hop forward until the step count runs out
				S_PASS: begin
					if (left_q == STEP_W'(1)) begin
						res_q   <= '{ram_rdata, ST_OK, count_q};
						state_q <= S_DONE;
					end else begin
						left_q <= left_q - STEP_W'(1);
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/ring_scoreboard_pkg.sv
// Scoreboard class for the circular ring list engine: ring prediction and response checks.
`timescale 1ns / 100ps

package ring_scoreboard_pkg;
	import crl_pkg::*;

	class ring_scoreboard;
		logic [SLOT_W-1:0] link_tbl [MAX_SLOTS];
		bit                link_set [MAX_SLOTS];
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
		logic [CNT_W-1:0]  members;
		rsp_item_t         awaited_rsp [$];
		int                errors;

		function new();
			for (int i = 0; i < MAX_SLOTS; i++) begin
				link_tbl[i] = '0;
				link_set[i] = 1'b0;
			end
			head = '0;
			tail = '0;
			members = CNT_ZERO;
			errors = 0;
		endfunction

		// Apply one operation to the tracked ring and return the response it yields
		function rsp_item_t ring_op_result(req_item_t it);
			rsp_item_t         r;
			logic [SLOT_W-1:0] s;
			logic [SLOT_W-1:0] prev;
			logic [SLOT_W-1:0] follow;
			logic [SLOT_W-1:0] cur;
			int                hops;
			bit                found;
			s = it.slot;
			r.result_slot = '0;
			r.status = ST_OK;
			case (it.mode)
				MODE_INSERT: begin
					if (members == CNT_FULL) begin
						r.status = ST_FULL;
					end else begin
						if (members == CNT_ZERO) begin
							head = s;
							tail = s;
							link_tbl[s] = s;
						end else begin
							link_tbl[s] = head;
							head = s;
							link_tbl[tail] = head;
						end
						link_set[s] = 1'b1;
						members++;
						r.result_slot = s;
					end
				end
				MODE_REMOVE: begin
					if (members == CNT_ZERO) begin
						r.status = ST_EMPTY;
					end else begin
						// search from the tail for the predecessor, give up after a full lap
						prev = tail;
						hops = 0;
						found = 1'b1;
						while (found && link_tbl[prev] != s) begin
							prev = link_tbl[prev];
							hops++;
							if (prev == tail || hops >= MAX_SLOTS)
								found = 1'b0;
						end
						if (!found) begin
							r.result_slot = head;
							r.status = ST_NOT_FOUND;
						end else if (members == CNT_ONE) begin
							head = '0;
							tail = '0;
							members = CNT_ZERO;
							r.status = ST_EMPTY;
						end else begin
							follow = link_tbl[s];
							if (s == head)
								head = follow;
							if (s == tail)
								tail = prev;
							link_tbl[prev] = follow;
							members--;
							r.result_slot = follow;
						end
					end
				end
				MODE_PASS: begin
					if (members == CNT_ZERO) begin
						r.status = ST_EMPTY;
					end else begin
						cur = s;
						for (int i = 0; i < int'(it.steps); i++)
							cur = link_tbl[cur];
						r.result_slot = cur;
					end
				end
				default: begin
					// clear keeps the links
					head = '0;
					tail = '0;
					members = CNT_ZERO;
				end
			endcase
			r.member_count = members;
			return r;
		endfunction

		function void note_request(req_item_t it);
			awaited_rsp.push_back(ring_op_result(it));
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("%0t ns mismatch: %s", $time, what);
		endtask

		// Compare a taken response against the oldest awaited one
		task check_response(rsp_item_t got);
			rsp_item_t want;
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("unawaited response slot %0d status %0d count %0d",
					got.result_slot, got.status, got.member_count));
			end else begin
				want = awaited_rsp.pop_front();
				if (got.result_slot !== want.result_slot)
					report_mismatch($sformatf("result_slot %0d, want %0d",
						got.result_slot, want.result_slot));
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						got.status, want.status));
				if (got.member_count !== want.member_count)
					report_mismatch($sformatf("member_count %0d, want %0d",
						got.member_count, want.member_count));
			end
		endtask

		// Walk the ring from the head as far as the member count reaches
		function bit on_ring(logic [SLOT_W-1:0] s);
			logic [SLOT_W-1:0] cur;
			bit                hit;
			cur = head;
			hit = 1'b0;
			for (int k = 0; k < int'(members); k++) begin
				if (cur == s)
					hit = 1'b1;
				cur = link_tbl[cur];
			end
			return hit;
		endfunction

		function logic [SLOT_W-1:0] pick_member();
			logic [SLOT_W-1:0] cur;
			if (members == CNT_ZERO)
				return SLOT_W'($urandom);
			cur = head;
			repeat ($urandom_range(0, int'(members) - 1))
				cur = link_tbl[cur];
			return cur;
		endfunction

		function logic [SLOT_W-1:0] pick_outsider();
			logic [SLOT_W-1:0] s;
			s = SLOT_W'($urandom);
			for (int k = 0; k < 32 && on_ring(s); k++)
				s = SLOT_W'($urandom);
			return s;
		endfunction

		// Any slot whose link has been written, member or not
		function logic [SLOT_W-1:0] pick_linked();
			logic [SLOT_W-1:0] s;
			s = SLOT_W'($urandom);
			for (int k = 0; k < 32 && !link_set[s]; k++)
				s = SLOT_W'($urandom);
			if (!link_set[s])
				s = head;
			return s;
		endfunction
	endclass

endpackage

### bench/tb_circular_ring_list_engine.sv
// Testbench top for the circular ring list engine: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps

module tb_circular_ring_list_engine;
	import crl_pkg::*;
	import ring_scoreboard_pkg::*;

	localparam int ITEM_TARGET  = 1250;
	localparam int DRAIN_CYCLES = 300;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	ring_scoreboard sb;
	int             sent;
	int             gap_pct;

	circular_ring_list_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Send one item: optional gap with valid low, then hold until taken
	task automatic push(mode_t m, logic [SLOT_W-1:0] s, logic [STEP_W-1:0] n);
		req_item_t it;
		it.mode = m;
		it.slot = s;
		it.steps = n;
		if ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		sb.note_request(it);
		sent++;
	endtask

	// Pass mostly short hops from a member, sometimes from any slot whose link has been written
	task automatic push_pass();
		logic [SLOT_W-1:0] s;
		logic [STEP_W-1:0] n;
		if ($urandom_range(0, 99) < 15)
			n = STEP_W'($urandom_range(0, 255));
		else
			n = STEP_W'($urandom_range(0, 20));
		s = SLOT_W'($urandom);
		if (sb.members != CNT_ZERO) begin
			if ($urandom_range(0, 99) < 70)
				s = sb.pick_member();
			else
				s = sb.pick_linked();
		end
		push(MODE_PASS, s, n);
	endtask

	// Any field values, but never a walk through a link not yet written
	task automatic push_noise();
		mode_t             m;
		logic [SLOT_W-1:0] s;
		logic [STEP_W-1:0] n;
		m = mode_t'($urandom_range(0, 3));
		s = SLOT_W'($urandom);
		n = STEP_W'($urandom);
		if (m == MODE_PASS && sb.members != CNT_ZERO && n != 0 && !sb.link_set[s])
			s = sb.pick_member();
		push(m, s, n);
	endtask

	// Take responses, stalling in random bursts
	initial begin
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 99) < gap_pct) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			if (rsp_valid)
				sb.check_response(rsp);
		end
	end

	initial begin
		int reps;
		int pick;
		sb = new();
		sent = 0;
		gap_pct = 20;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring: remove and pass
		push(MODE_REMOVE, 4'hF, 8'hFF);
		push(MODE_PASS, 4'hF, 8'hFF);
		// lone member links to itself, then leaves
		push(MODE_INSERT, 4'h0, 8'h00);
		push(MODE_PASS, 4'h0, 8'hFF);
		push(MODE_REMOVE, 4'h0, 8'h00);
		// three members, walk them
		push(MODE_INSERT, 4'hF, 8'h00);
		push(MODE_INSERT, 4'h3, 8'hAA);
		push(MODE_INSERT, 4'h7, 8'h55);
		push(MODE_PASS, 4'h7, 8'h00);
		push(MODE_PASS, 4'hF, 8'hFF);
		push(MODE_PASS, 4'hF, 8'h01);
		// remove an outsider, the head, the tail
		push(MODE_REMOVE, 4'h9, 8'h00);
		push(MODE_REMOVE, 4'h7, 8'h00);
		push(MODE_REMOVE, 4'hF, 8'h00);
		// insert a member again, then a new one
		push(MODE_INSERT, 4'h3, 8'h00);
		push(MODE_INSERT, 4'hA, 8'h00);
		// pass from an outsider with a stale link
		push(MODE_PASS, 4'h0, 8'h05);
		// clear keeps links but empties the ring
		push(MODE_CLEAR, 4'hF, 8'hFF);
		push(MODE_PASS, 4'h3, 8'h0A);
		push(MODE_REMOVE, 4'h3, 8'h00);
		push(MODE_INSERT, 4'h5, 8'h00);
		push(MODE_PASS, 4'hA, 8'h03);
		push(MODE_CLEAR, 4'h0, 8'h00);

		// random sequences: fills, drains, mixed traffic and noise
		while (sent < ITEM_TARGET) begin
			if (sent > ITEM_TARGET * 85 / 100) begin
				gap_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: gap_pct = 0;
					1: gap_pct = 10;
					2: gap_pct = 30;
					default: gap_pct = 60;
				endcase
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// fill to full, then knock once more
					while (sb.members != CNT_FULL) begin
						if ($urandom_range(0, 4) == 0)
							push_pass();
						else
							push(MODE_INSERT, sb.pick_outsider(), STEP_W'($urandom));
					end
					push(MODE_INSERT, SLOT_W'($urandom), STEP_W'($urandom));
				end
				3, 4: begin
					// drain member by member, then remove a random slot once more
					for (int k = 0; k < 40 && sb.members != CNT_ZERO; k++) begin
						if ($urandom_range(0, 4) == 0)
							push_pass();
						else
							push(MODE_REMOVE, sb.pick_member(), STEP_W'($urandom));
					end
					push(MODE_REMOVE, SLOT_W'($urandom), STEP_W'($urandom));
				end
				5, 6, 7, 8: begin
					reps = $urandom_range(5, 30);
					repeat (reps) begin
						pick = $urandom_range(0, 99);
						if (pick < 35)
							push(MODE_INSERT, ($urandom_range(0, 9) < 7) ? sb.pick_outsider()
								: SLOT_W'($urandom), STEP_W'($urandom));
						else if (pick < 70)
							push(MODE_REMOVE, ($urandom_range(0, 3) < 3) ? sb.pick_member()
								: SLOT_W'($urandom), STEP_W'($urandom));
						else if (pick < 95)
							push_pass();
						else
							push(MODE_CLEAR, SLOT_W'($urandom), STEP_W'($urandom));
					end
				end
				default: begin
					reps = $urandom_range(3, 12);
					repeat (reps) push_noise();
				end
			endcase
		end
		req_valid <= 1'b0;

		// wait out the remaining responses and any late extras
		while (sb.awaited_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#12_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
design/crl_pkg.sv
design/crl_ram.sv
design/crl_walker.sv
design/circular_ring_list_engine.sv
bench/ring_scoreboard_pkg.sv
bench/tb_circular_ring_list_engine.sv
